[hw/rtl/crcdf_pkg.sv]
package crcdf_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned HDR_CNT_W    = 4;
    localparam int unsigned LEN_W        = 24;
    localparam int unsigned WORD_W       = 32;

    localparam logic [31:0]    CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0]    CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX = 24'hFF_FFFF;

    // One result of the deframer, as it sits in the output register.
    typedef struct packed {
        logic [7:0]        out_byte;
        logic              data_valid;
        logic [WORD_W-1:0] message_type;
        logic              end_of_frame;
        logic              check_ok;
        logic              frame_error;
    } res_t;

    // Reflected CRC-32 update over one byte, bit by bit, least significant first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/crcdf_input_stage.sv]
module crcdf_input_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte
);
    import crcdf_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;

    // The register may refill in the same cycle as the core takes its byte.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            byte_next  = s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

[hw/rtl/crcdf_frame_core.sv]
module crcdf_frame_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_valid,
    input  logic [7:0]                 item_byte,
    input  logic [crcdf_pkg::LEN_W-1:0] max_len,
    input  logic                       out_ready,
    output logic                       take,
    output logic                       res_valid,
    output crcdf_pkg::res_t            res
);
    import crcdf_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    localparam logic [1:0] WORD_LEN   = 2'd0;
    localparam logic [1:0] WORD_CHECK = 2'd1;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

    phase_t               phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [WORD_W-1:0]    len_reg, len_next;
    logic [WORD_W-1:0]    check_reg, check_next;
    logic [WORD_W-1:0]    type_reg, type_next;
    logic [LEN_W-1:0]     left_reg, left_next;
    logic [31:0]          crc_reg, crc_next;
    logic                 res_valid_reg, res_valid_next;
    res_t                 res_reg, res_next;

    logic [31:0]          crc_new;
    logic [LEN_W-1:0]     left_dec;
    logic                 ok;

    // An item moves on only when the result register has room for it.
    assign take = item_valid && (!res_valid_reg || out_ready);

    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_next       = len_reg;
        check_next     = check_reg;
        type_next      = type_reg;
        left_next      = left_reg;
        crc_next       = crc_reg;
        res_valid_next = res_valid_reg && !out_ready;
        res_next       = res_reg;
        crc_new        = crc_byte(crc_reg, item_byte);
        left_dec       = left_reg - LEN_W'(1);
        ok             = 1'b0;

        if (take) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    case (hdr_cnt_reg[3:2])
                        WORD_LEN:   len_next   = {len_reg[WORD_W-9:0], item_byte};
                        WORD_CHECK: check_next = {check_reg[WORD_W-9:0], item_byte};
                        default:    type_next  = {type_reg[WORD_W-9:0], item_byte};
                    endcase
                    if (hdr_cnt_reg == HDR_LAST) begin
                        hdr_cnt_next = '0;
                        crc_next     = CRC_INIT;
                        res_next.out_byte     = 8'd0;
                        res_next.data_valid   = 1'b0;
                        res_next.message_type = type_next;
                        res_next.end_of_frame = 1'b1;
                        if (len_next > {8'd0, max_len}) begin
                            phase_next           = PH_ERROR;
                            res_valid_next       = 1'b1;
                            res_next.check_ok    = 1'b0;
                            res_next.frame_error = 1'b1;
                        end else if (len_next == '0) begin
                            ok                   = (check_next == '0);
                            phase_next           = ok ? PH_HEADER : PH_ERROR;
                            res_valid_next       = 1'b1;
                            res_next.check_ok    = ok;
                            res_next.frame_error = 1'b0;
                        end else begin
                            left_next  = len_next[LEN_W-1:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                    end
                end
                PH_PAYLOAD: begin
                    crc_next              = crc_new;
                    left_next             = left_dec;
                    res_valid_next        = 1'b1;
                    res_next.out_byte     = item_byte;
                    res_next.data_valid   = 1'b1;
                    res_next.message_type = type_reg;
                    res_next.frame_error  = 1'b0;
                    if (left_dec != '0) begin
                        res_next.end_of_frame = 1'b0;
                        res_next.check_ok     = 1'b0;
                    end else begin
                        ok                    = ((~crc_new) == check_reg);
                        phase_next            = ok ? PH_HEADER : PH_ERROR;
                        res_next.end_of_frame = 1'b1;
                        res_next.check_ok     = ok;
                    end
                end
                default: begin
                    // Sticky error: bytes are dropped until reset.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            len_reg       <= '0;
            check_reg     <= '0;
            type_reg      <= '0;
            left_reg      <= '0;
            crc_reg       <= CRC_INIT;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            len_reg       <= len_next;
            check_reg     <= check_next;
            type_reg      <= type_next;
            left_reg      <= left_next;
            crc_reg       <= crc_next;
            res_valid_reg <= res_valid_next;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hw/rtl/crc32_checked_frame_deframer.sv]
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_in_byte
// m_        out        m_valid / m_ready   m_out_byte, m_data_valid, m_message_type,
//                                          m_end_of_frame, m_check_ok, m_frame_error
// cfg_      in         cfg_we              cfg_wdata (max_payload_length)
//
// One byte is taken every cycle while the result register is free or m_ready is high; a
// byte moves from the input register through the CRC and header logic into the result
// register, from which its result shows on m_.
// Reset is synchronous and active low; it clears the frame state, the sticky error and
// the limit register (all ones).
// A stalled result holds the result register, and the input register then fills and
// drops s_ready until m_ready returns.
module crc32_checked_frame_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [crcdf_pkg::LEN_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_in_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_data_valid,
    output logic [crcdf_pkg::WORD_W-1:0] m_message_type,
    output logic                        m_end_of_frame,
    output logic                        m_check_ok,
    output logic                        m_frame_error
);
    import crcdf_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             take;
    logic             item_valid;
    logic [7:0]       item_byte;
    res_t             res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LEN_MAX;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    crcdf_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    crcdf_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .max_len    (max_len_reg),
        .out_ready  (m_ready),
        .take       (take),
        .res_valid  (m_valid),
        .res        (res)
    );

    assign m_out_byte     = res.out_byte;
    assign m_data_valid   = res.data_valid;
    assign m_message_type = res.message_type;
    assign m_end_of_frame = res.end_of_frame;
    assign m_check_ok     = res.check_ok;
    assign m_frame_error  = res.frame_error;

endmodule

[hw/rtl/crcdf_checker.sv]
module crcdf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_out_byte,
    input logic                        m_data_valid,
    input logic [crcdf_pkg::WORD_W-1:0] m_message_type,
    input logic                        m_end_of_frame,
    input logic                        m_check_ok,
    input logic                        m_frame_error
);
    import crcdf_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_message_type)
            && $stable(m_end_of_frame) && $stable(m_check_ok))
        else $error("result changed while stalled");

    // A result without data only ever closes a frame, and carries a zero byte.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_valid |-> m_end_of_frame && (m_out_byte == 8'd0))
        else $error("data-less result is not an end of frame");

    // A length error is data-less and never reports a good check.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_error |-> m_end_of_frame && !m_check_ok && !m_data_valid)
        else $error("frame error result malformed");

    // After a failed frame the block goes quiet until reset.
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_end_of_frame && !m_check_ok |=> !m_valid)
        else $error("result after sticky error");

    // With the result register empty the input is never held off.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input held off with no result waiting");

endmodule

bind crc32_checked_frame_deframer crcdf_checker u_checker (.*);
